### hdl/terrain_hillshade_assert.svh
// ---------------------------------------------------------------------------
// terrain_hillshade assertion macros
// shared property wrappers, clocked on i_clk and held off during reset
// ---------------------------------------------------------------------------
`ifndef TERRAIN_HILLSHADE_ASSERT_SVH
`define TERRAIN_HILLSHADE_ASSERT_SVH

`ifndef SYNTHESIS
`define TH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");
`define TH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");
`else
`define TH_ASSERT_IMP(lbl, ante, cons)
`define TH_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hdl/th_pkg.sv
// ---------------------------------------------------------------------------
// th_pkg
// shared types and constants of the hillshade block
// ---------------------------------------------------------------------------
package th_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int COL_W       = 12;

    // configuration register indexes
    localparam logic [2:0] CFG_COLUMN_COUNT   = 3'd0;
    localparam logic [2:0] CFG_ROW_COUNT      = 3'd1;
    localparam logic [2:0] CFG_NO_DATA_VALUE  = 3'd2;
    localparam logic [2:0] CFG_GRADIENT_SCALE = 3'd3;
    localparam logic [2:0] CFG_SUN_X          = 3'd4;
    localparam logic [2:0] CFG_SUN_Y          = 3'd5;
    localparam logic [2:0] CFG_SUN_Z          = 3'd6;

    localparam logic [12:0] RST_COLUMN_COUNT   = 13'd4096;
    localparam logic [15:0] RST_ROW_COUNT      = 16'd4096;
    localparam logic [31:0] RST_NO_DATA_VALUE  = -32'sd9999;
    localparam logic [31:0] RST_GRADIENT_SCALE = 32'd271800;
    localparam logic [15:0] RST_SUN_X          = 16'd16384;
    localparam logic [15:0] RST_SUN_Y          = -16'sd16384;
    localparam logic [15:0] RST_SUN_Z          = 16'd23170;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_CALC,
        ST_PUSH
    } t_top_state;

    typedef enum logic [3:0] {
        C_IDLE,
        C_SLX,
        C_SLY,
        C_GY,
        C_SQY,
        C_DTX,
        C_DTY,
        C_ACC,
        C_SQRT,
        C_DIVCHK,
        C_DIV,
        C_DONE
    } t_core_state;

    typedef struct packed {
        logic        start;
        logic [31:0] left;
        logic [31:0] right;
        logic [31:0] up;
        logic [31:0] down;
    } t_core_req;

    typedef struct packed {
        logic        done;
        logic [15:0] shade;
    } t_core_rsp;

    typedef struct packed {
        logic [15:0] shade;
        logic        last;
        logic        eot;
    } t_result;

endpackage

### hdl/th_shade_core.sv
// ---------------------------------------------------------------------------
// th_shade_core
// shades one cell: slopes, normal length and lambert term through one shared
// multiplier, a bit-pair square root and a restoring divide
// ---------------------------------------------------------------------------
module th_shade_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  th_pkg::t_core_req  i_req,
    input  logic [31:0]        i_no_data_value,
    input  logic [31:0]        i_gradient_scale,
    input  logic [15:0]        i_sun_x,
    input  logic [15:0]        i_sun_y,
    input  logic [15:0]        i_sun_z,
    output th_pkg::t_core_rsp  o_rsp
);

    th_pkg::t_core_state r_state, n_state;

    logic signed [32:0] r_dx, r_dy;
    logic signed [31:0] r_gx, r_gy;
    logic signed [65:0] r_prod;
    logic [63:0]        r_sum;
    logic signed [49:0] r_num;
    logic [63:0]        r_v, r_root, r_bit;
    logic [49:0]        r_rem, r_dv;
    logic [15:0]        r_q;
    logic [4:0]         r_cnt;
    logic [15:0]        r_shade;

    logic signed [32:0] w_mul_a, w_mul_b;
    logic signed [65:0] w_mul_p;
    logic [32:0]        w_mag_x, w_mag_y;
    logic               w_no_data;
    logic [63:0]        w_try;
    logic [49:0]        w_num2, w_lim;

    function automatic logic signed [31:0] f_slope(input logic [65:0] p, input logic neg);
        logic [30:0] q;
        q = (p[63:39] != '0) ? '1 : p[38:8];
        return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    assign w_mag_x = r_dx[32] ? 33'(-r_dx) : r_dx;
    assign w_mag_y = r_dy[32] ? 33'(-r_dy) : r_dy;

    assign w_no_data = (i_req.left == i_no_data_value) || (i_req.right == i_no_data_value) ||
                       (i_req.up == i_no_data_value) || (i_req.down == i_no_data_value);

    // operand selection for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            th_pkg::C_SLX: begin
                w_mul_a = w_mag_x;
                w_mul_b = {1'b0, i_gradient_scale};
            end
            th_pkg::C_SLY: begin
                w_mul_a = w_mag_y;
                w_mul_b = {1'b0, i_gradient_scale};
            end
            th_pkg::C_GY: begin
                w_mul_a = {r_gx[31], r_gx};
                w_mul_b = {r_gx[31], r_gx};
            end
            th_pkg::C_SQY: begin
                w_mul_a = {r_gy[31], r_gy};
                w_mul_b = {r_gy[31], r_gy};
            end
            th_pkg::C_DTX: begin
                w_mul_a = {r_gx[31], r_gx};
                w_mul_b = {{17{i_sun_x[15]}}, i_sun_x};
            end
            th_pkg::C_DTY: begin
                w_mul_a = {r_gy[31], r_gy};
                w_mul_b = {{17{i_sun_y[15]}}, i_sun_y};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;
    assign w_try   = r_root + r_bit;
    assign w_num2  = {r_num[48:0], 1'b0};
    assign w_lim   = {2'b00, r_root[31:0], 16'h0000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= th_pkg::C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            th_pkg::C_IDLE: begin
                if (i_req.start) begin
                    n_state = w_no_data ? th_pkg::C_DONE : th_pkg::C_SLX;
                end
            end
            th_pkg::C_SLX:  n_state = th_pkg::C_SLY;
            th_pkg::C_SLY:  n_state = th_pkg::C_GY;
            th_pkg::C_GY:   n_state = th_pkg::C_SQY;
            th_pkg::C_SQY:  n_state = th_pkg::C_DTX;
            th_pkg::C_DTX:  n_state = th_pkg::C_DTY;
            th_pkg::C_DTY:  n_state = th_pkg::C_ACC;
            th_pkg::C_ACC:  n_state = th_pkg::C_SQRT;
            th_pkg::C_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = th_pkg::C_DIVCHK;
                end
            end
            th_pkg::C_DIVCHK: begin
                if (r_num <= 0 || w_num2 >= w_lim) begin
                    n_state = th_pkg::C_DONE;
                end else begin
                    n_state = th_pkg::C_DIV;
                end
            end
            th_pkg::C_DIV: begin
                if (r_cnt == '0) begin
                    n_state = th_pkg::C_DONE;
                end
            end
            th_pkg::C_DONE: n_state = th_pkg::C_IDLE;
            default:        n_state = th_pkg::C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_p;
        case (r_state)
            th_pkg::C_IDLE: begin
                r_dx    <= $signed({i_req.right[31], i_req.right})
                         - $signed({i_req.left[31], i_req.left});
                r_dy    <= $signed({i_req.down[31], i_req.down})
                         - $signed({i_req.up[31], i_req.up});
                r_shade <= '0;
            end
            th_pkg::C_SLY: r_gx <= f_slope(r_prod, r_dx[32]);
            th_pkg::C_GY:  r_gy <= f_slope(r_prod, r_dy[32]);
            th_pkg::C_SQY: r_sum <= 64'h1_0000_0000 + r_prod[63:0];
            th_pkg::C_DTX: r_sum <= r_sum + r_prod[63:0];
            th_pkg::C_DTY: r_num <= $signed({{18{i_sun_z[15]}}, i_sun_z, 16'h0000})
                                  - $signed(r_prod[49:0]);
            th_pkg::C_ACC: begin
                r_num  <= r_num - $signed(r_prod[49:0]);
                r_v    <= r_sum;
                r_root <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
                r_cnt  <= 5'd31;
            end
            th_pkg::C_SQRT: begin
                // one result bit per step
                if (r_v >= w_try) begin
                    r_v    <= r_v - w_try;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 5'd1;
            end
            th_pkg::C_DIVCHK: begin
                if (r_num <= 0) begin
                    r_shade <= '0;
                end else if (w_num2 >= w_lim) begin
                    r_shade <= 16'hFFFF;
                end
                r_rem <= w_num2;
                r_dv  <= {3'b000, r_root[31:0], 15'h0000};
                r_q   <= '0;
                r_cnt <= 5'd15;
            end
            th_pkg::C_DIV: begin
                if (r_rem >= r_dv) begin
                    r_rem <= r_rem - r_dv;
                    r_q   <= {r_q[14:0], 1'b1};
                end else begin
                    r_q   <= {r_q[14:0], 1'b0};
                end
                r_dv  <= r_dv >> 1;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    r_shade <= {r_q[14:0], (r_rem >= r_dv)};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done  = (r_state == th_pkg::C_DONE);
    assign o_rsp.shade = r_shade;

    `include "terrain_hillshade_assert.svh"

    `TH_ASSERT_IMP(a_start_when_idle, i_req.start, r_state == th_pkg::C_IDLE)
    `TH_ASSERT_NXT(a_done_returns, o_rsp.done, r_state == th_pkg::C_IDLE)
    `TH_ASSERT_IMP(a_root_floor, r_state == th_pkg::C_DIVCHK, r_root[31:16] != '0)

endmodule

### hdl/terrain_hillshade.sv
// ---------------------------------------------------------------------------
// terrain_hillshade
// streaming hillshade of an elevation tile with two line stores
// ---------------------------------------------------------------------------
// elevation samples enter on the s_axis request channel in raster order, one
// at a time; shade results leave on m_axis. tlast marks the last result caused
// by one sample, tuser marks the result for the tile's final cell. a sample of
// the first row gives no result, every later sample gives one result, and a
// sample of the last row gives a second, zero result for the last-row cell.
// each sample passes an accept in the idle state, three line-store read and write
// states and a push state; an interior cell also runs the shading core, which
// ends early when the shade saturates or a neighbour holds no data. the core's
// 32-step square root and 16-step divide take most of its time.
// results sit in a two-entry output buffer; the next sample is taken while
// they wait, and a stalled receiver holds the block only when that sample's
// results are ready to go out and the buffer is not yet empty.
// configuration is written through i_cfg_we/i_cfg_index/i_cfg_wdata while the
// block is idle. reset restores register defaults and the row and column
// positions; line stores hold nothing defined until written.
// ---------------------------------------------------------------------------
module terrain_hillshade (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] elevation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] shade
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // [0] end_of_tile
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);

    localparam int CW = th_pkg::COL_W;

    logic [12:0] r_column_count;
    logic [15:0] r_row_count;
    logic [31:0] r_no_data_value;
    logic [31:0] r_gradient_scale;
    logic [15:0] r_sun_x, r_sun_y, r_sun_z;

    th_pkg::t_top_state r_state, n_state;

    logic [CW-1:0] r_colp, r_c;
    logic [15:0]   r_rowp;
    logic [31:0]   r_x, r_left, r_right;
    logic          r_last_col, r_last_row, r_has_out, r_interior;
    logic [15:0]   r_shade;

    logic [31:0] r_upper_mem  [th_pkg::MAX_COLUMNS];
    logic [31:0] r_middle_mem [th_pkg::MAX_COLUMNS];
    logic [31:0] r_up_rd, r_mid_rd;
    logic [CW-1:0] w_addr_u, w_addr_m;
    logic          w_store_we;

    th_pkg::t_result r_out0, r_out1;
    logic [1:0]      r_out_cnt;

    th_pkg::t_core_req w_req;
    th_pkg::t_core_rsp w_rsp;

    logic [12:0]   w_cols;
    logic [15:0]   w_rows;
    logic [CW-1:0] w_last_idx, w_c;
    logic          w_last_col, w_last_row, w_accept, w_pop;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count   <= th_pkg::RST_COLUMN_COUNT;
            r_row_count      <= th_pkg::RST_ROW_COUNT;
            r_no_data_value  <= th_pkg::RST_NO_DATA_VALUE;
            r_gradient_scale <= th_pkg::RST_GRADIENT_SCALE;
            r_sun_x          <= th_pkg::RST_SUN_X;
            r_sun_y          <= th_pkg::RST_SUN_Y;
            r_sun_z          <= th_pkg::RST_SUN_Z;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                th_pkg::CFG_COLUMN_COUNT:   r_column_count   <= i_cfg_wdata[12:0];
                th_pkg::CFG_ROW_COUNT:      r_row_count      <= i_cfg_wdata[15:0];
                th_pkg::CFG_NO_DATA_VALUE:  r_no_data_value  <= i_cfg_wdata;
                th_pkg::CFG_GRADIENT_SCALE: r_gradient_scale <= i_cfg_wdata;
                th_pkg::CFG_SUN_X:          r_sun_x          <= i_cfg_wdata[15:0];
                th_pkg::CFG_SUN_Y:          r_sun_y          <= i_cfg_wdata[15:0];
                th_pkg::CFG_SUN_Z:          r_sun_z          <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // position of the incoming sample, counts clamped to their usable range
    always_comb begin
        if (r_column_count < 13'd3) begin
            w_cols = 13'd3;
        end else if (r_column_count > 13'(th_pkg::MAX_COLUMNS)) begin
            w_cols = 13'(th_pkg::MAX_COLUMNS);
        end else begin
            w_cols = r_column_count;
        end
        w_rows     = (r_row_count < 16'd3) ? 16'd3 : r_row_count;
        w_last_idx = CW'(w_cols - 13'd1);
        w_c        = (r_colp > w_last_idx) ? w_last_idx : r_colp;
        w_last_col = (w_c == w_last_idx);
        w_last_row = (r_rowp >= w_rows - 16'd1);
    end

    assign s_axis_tready = (r_state == th_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= th_pkg::ST_IDLE;
            r_colp  <= '0;
            r_rowp  <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                if (w_last_col) begin
                    r_colp <= '0;
                    r_rowp <= w_last_row ? 16'd0 : r_rowp + 16'd1;
                end else begin
                    r_colp <= w_c + CW'(1);
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            th_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = th_pkg::ST_RD0;
                end
            end
            th_pkg::ST_RD0: n_state = th_pkg::ST_RD1;
            th_pkg::ST_RD1: n_state = th_pkg::ST_RD2;
            th_pkg::ST_RD2: n_state = r_interior ? th_pkg::ST_CALC : th_pkg::ST_PUSH;
            th_pkg::ST_CALC: begin
                if (w_rsp.done) begin
                    n_state = th_pkg::ST_PUSH;
                end
            end
            th_pkg::ST_PUSH: begin
                if (r_out_cnt == 2'd0) begin
                    n_state = th_pkg::ST_IDLE;
                end
            end
            default: n_state = th_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x        <= s_axis_tdata;
            r_c        <= w_c;
            r_last_col <= w_last_col;
            r_last_row <= w_last_row;
            r_has_out  <= (r_rowp != 16'd0);
            r_interior <= (r_rowp >= 16'd2) && (w_c != '0) && !w_last_col;
        end
        if (r_state == th_pkg::ST_RD1) begin
            r_left  <= r_up_rd;
            r_right <= r_mid_rd;
        end
        if (r_state == th_pkg::ST_RD2) begin
            r_shade <= '0;
        end else if (r_state == th_pkg::ST_CALC && w_rsp.done) begin
            r_shade <= w_rsp.shade;
        end
    end

    // neighbours first, then the column itself; the column is rewritten last
    assign w_addr_u   = (r_state == th_pkg::ST_RD0) ? r_c - CW'(1) : r_c;
    assign w_addr_m   = (r_state == th_pkg::ST_RD0) ? r_c + CW'(1) : r_c;
    assign w_store_we = (r_state == th_pkg::ST_RD2);

    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_upper_mem[r_c] <= r_mid_rd;
        end
        r_up_rd <= r_upper_mem[w_addr_u];
    end

    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_middle_mem[r_c] <= r_x;
        end
        r_mid_rd <= r_middle_mem[w_addr_m];
    end

    assign w_req.start = (r_state == th_pkg::ST_RD2) && r_interior;
    assign w_req.left  = r_left;
    assign w_req.right = r_right;
    assign w_req.up    = r_up_rd;
    assign w_req.down  = r_x;

    th_shade_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (w_req),
        .i_no_data_value  (r_no_data_value),
        .i_gradient_scale (r_gradient_scale),
        .i_sun_x          (r_sun_x),
        .i_sun_y          (r_sun_y),
        .i_sun_z          (r_sun_z),
        .o_rsp            (w_rsp)
    );

    // output buffer, loaded only when empty
    assign w_pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cnt <= '0;
        end else if (r_state == th_pkg::ST_PUSH && r_out_cnt == 2'd0) begin
            if (r_has_out) begin
                r_out_cnt <= r_last_row ? 2'd2 : 2'd1;
            end
        end else if (w_pop) begin
            r_out_cnt <= r_out_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == th_pkg::ST_PUSH && r_out_cnt == 2'd0) begin
            r_out0.shade <= r_shade;
            r_out0.last  <= !r_last_row;
            r_out0.eot   <= 1'b0;
            r_out1.shade <= '0;
            r_out1.last  <= 1'b1;
            r_out1.eot   <= r_last_col;
        end else if (w_pop) begin
            r_out0 <= r_out1;
        end
    end

    assign m_axis_tvalid = (r_out_cnt != 2'd0);
    assign m_axis_tdata  = r_out0.shade;
    assign m_axis_tlast  = r_out0.last;
    assign m_axis_tuser  = r_out0.eot;

    `include "terrain_hillshade_assert.svh"

    `TH_ASSERT_IMP(a_done_in_calc, w_rsp.done, r_state == th_pkg::ST_CALC)
    `TH_ASSERT_NXT(a_one_at_a_time, w_accept, !s_axis_tready)
    `TH_ASSERT_NXT(a_push_shows, r_state == th_pkg::ST_PUSH && r_out_cnt == 2'd0 && r_has_out,
                   m_axis_tvalid)
    `TH_ASSERT_IMP(a_buffer_bound, r_out_cnt == 2'd2, r_out0.last == 1'b0)

endmodule
